// ===== rtl/hbd_pkg.sv =====
`default_nettype none
package hbd_pkg;

	localparam int NODE_COUNT = 512;
	localparam int IDX_W = 9;
	localparam int CHAR_W = 8;

	// Indices are 9 bits wide, so entries above 511 can never be reached.
	localparam int RAM_DEPTH = (NODE_COUNT < (1 << IDX_W)) ? NODE_COUNT : (1 << IDX_W);
	localparam int RAM_AW = $clog2(RAM_DEPTH);

	localparam logic [1:0] OP_LOAD   = 2'd0;
	localparam logic [1:0] OP_DECODE = 2'd1;
	localparam logic [1:0] OP_END    = 2'd2;

	localparam logic [CHAR_W-1:0] CHAR_LEFT  = 8'h30;
	localparam logic [CHAR_W-1:0] CHAR_RIGHT = 8'h31;

	localparam int OUT_DEPTH = 3;
	localparam int LVL_W = $clog2(OUT_DEPTH + 1);
	localparam int PTR_W = $clog2(OUT_DEPTH);

	typedef struct packed {
		logic [IDX_W-1:0]  left;
		logic [IDX_W-1:0]  right;
		logic              leaf;
		logic [CHAR_W-1:0] letter;
	} node_rec_t;

	typedef struct packed {
		logic [1:0]        opcode;
		logic [IDX_W-1:0]  node_index;
		logic [IDX_W-1:0]  left_index;
		logic [IDX_W-1:0]  right_index;
		logic              is_leaf;
		logic [CHAR_W-1:0] leaf_letter;
		logic [CHAR_W-1:0] code_char;
	} in_item_t;

	typedef struct packed {
		logic [CHAR_W-1:0] symbol;
		logic              symbol_valid;
		logic              stream_end;
		logic              incomplete;
	} out_item_t;

	function automatic logic in_table(input logic [IDX_W-1:0] idx);
		return 32'(idx) < 32'(RAM_DEPTH);
	endfunction

endpackage
`default_nettype wire

// ===== rtl/hbd_if.sv =====
`default_nettype none
interface hbd_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  opcode;
	logic [8:0]  node_index;
	logic [8:0]  left_index;
	logic [8:0]  right_index;
	logic        is_leaf;
	logic [7:0]  leaf_letter;
	logic [7:0]  code_char;

	modport source (
		output valid, opcode, node_index, left_index, right_index, is_leaf, leaf_letter,
			code_char,
		input ready
	);
	modport sink (
		input valid, opcode, node_index, left_index, right_index, is_leaf, leaf_letter,
			code_char,
		output ready
	);
endinterface

interface hbd_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  symbol;
	logic        symbol_valid;
	logic        stream_end;
	logic        incomplete;

	modport source (
		output valid, symbol, symbol_valid, stream_end, incomplete,
		input ready
	);
	modport sink (
		input valid, symbol, symbol_valid, stream_end, incomplete,
		output ready
	);
endinterface
`default_nettype wire

// ===== rtl/hbd_ram.sv =====
`default_nettype none
module hbd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr_a,
	input  wire logic [AW-1:0]    raddr_b,
	output logic      [WIDTH-1:0] rdata_a,
	output logic      [WIDTH-1:0] rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write-first on both read ports
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= (we && waddr == raddr_a) ? wdata : mem[raddr_a];
		rdata_b <= (we && waddr == raddr_b) ? wdata : mem[raddr_b];
	end

endmodule
`default_nettype wire

// ===== rtl/hbd_out_fifo.sv =====
`default_nettype none
module hbd_out_fifo
	import hbd_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire out_item_t        push_item,
	output logic      [LVL_W-1:0] level,
	output logic                  out_valid,
	output out_item_t             out_item,
	input  wire logic             out_ready
);

	out_item_t        mem_q [OUT_DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [LVL_W-1:0] cnt_q;
	logic             pop;

	function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(OUT_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign out_valid = (cnt_q != '0);
	assign out_item  = mem_q[rd_q];
	assign pop       = out_valid && out_ready;
	assign level     = cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wrap_inc(wr_q);
			end
			if (pop) begin
				rd_q <= wrap_inc(rd_q);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/hbd_walk.sv =====
`default_nettype none
module hbd_walk
	import hbd_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire logic [IDX_W-1:0] cfg_data,
	input  wire logic             in_valid,
	input  wire in_item_t         in_item,
	output logic                  in_ready,
	input  wire logic [LVL_W-1:0] level,
	output logic                  res_valid,
	output out_item_t             res_item
);

	in_item_t         item_s1;
	logic             valid_s1;
	logic             res_valid_s2;
	logic             is_end_s2;
	logic             inc_s2;

	// p_q is the pointer last read on port A; after a decode it is the child
	// before the leaf check, which is resolved in the following cycle.
	logic [IDX_W-1:0] p_q;
	logic             p_ok_q;
	logic [IDX_W-1:0] root_q;
	logic             root_ok_q;

	node_rec_t        ram_a;
	node_rec_t        ram_b;
	node_rec_t        rec_a;
	node_rec_t        rec_root;
	node_rec_t        cur_rec;
	node_rec_t        wr_rec;
	logic [IDX_W-1:0] cur_wp;
	logic [IDX_W-1:0] addr_next;
	logic [IDX_W-1:0] raddr_b;
	logic [IDX_W-1:0] child;
	logic             pending;
	logic             hit;
	logic             needs_room;
	logic             room;
	logic             exec;
	logic             do_load;

	assign rec_a    = p_ok_q ? ram_a : '0;
	assign rec_root = root_ok_q ? ram_b : '0;
	assign pending  = res_valid_s2 && !is_end_s2;
	assign hit      = pending && rec_a.leaf;
	assign cur_rec  = hit ? rec_root : rec_a;
	assign cur_wp   = hit ? root_q : p_q;

	assign needs_room = (item_s1.opcode == OP_DECODE) || (item_s1.opcode == OP_END);
	assign room       = (({1'b0, level} + (LVL_W + 1)'(res_valid_s2)) < (LVL_W + 1)'(OUT_DEPTH));
	assign exec       = valid_s1 && (!needs_room || room);
	assign in_ready   = !valid_s1 || exec;
	assign do_load    = exec && (item_s1.opcode == OP_LOAD) && in_table(item_s1.node_index);

	assign wr_rec = '{
		left:   item_s1.left_index,
		right:  item_s1.right_index,
		leaf:   item_s1.is_leaf,
		letter: item_s1.leaf_letter
	};

	always_comb begin
		if (item_s1.code_char == CHAR_LEFT) begin
			child = cur_rec.left;
		end else if (item_s1.code_char == CHAR_RIGHT) begin
			child = cur_rec.right;
		end else begin
			child = cur_wp;
		end
	end

	always_comb begin
		addr_next = cur_wp;
		if (cfg_we) begin
			addr_next = cfg_data;
		end else if (exec) begin
			case (item_s1.opcode)
				OP_DECODE: addr_next = child;
				OP_END:    addr_next = root_q;
				default:   addr_next = cur_wp;
			endcase
		end
	end

	assign raddr_b = cfg_we ? cfg_data : root_q;

	hbd_ram #(
		.WIDTH ($bits(node_rec_t)),
		.DEPTH (RAM_DEPTH)
	) u_table (
		.clk     (clk),
		.we      (do_load),
		.waddr   (item_s1.node_index[RAM_AW-1:0]),
		.wdata   (wr_rec),
		.raddr_a (addr_next[RAM_AW-1:0]),
		.raddr_b (raddr_b[RAM_AW-1:0]),
		.rdata_a (ram_a),
		.rdata_b (ram_b)
	);

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
		is_end_s2 <= (item_s1.opcode == OP_END);
		inc_s2    <= (cur_wp != root_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			res_valid_s2 <= 1'b0;
			p_q          <= '0;
			p_ok_q       <= in_table('0);
			root_q       <= '0;
			root_ok_q    <= in_table('0);
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			res_valid_s2 <= exec && needs_room;
			p_q          <= addr_next;
			p_ok_q       <= in_table(addr_next);
			if (cfg_we) begin
				root_q <= cfg_data;
			end
			root_ok_q <= in_table(raddr_b);
		end
	end

	assign res_valid = res_valid_s2;

	always_comb begin
		if (is_end_s2) begin
			res_item = '{symbol: '0, symbol_valid: 1'b0, stream_end: 1'b1, incomplete: inc_s2};
		end else begin
			res_item = '{
				symbol:       rec_a.leaf ? rec_a.letter : '0,
				symbol_valid: rec_a.leaf,
				stream_end:   1'b0,
				incomplete:   1'b0
			};
		end
	end

endmodule
`default_nettype wire

// ===== rtl/huffman_bit_decoder.sv =====
`default_nettype none
// Huffman tree-walk decoder. Load items write node records into a 512-entry
// node table (entries are undefined until loaded); decode items step the walk
// one code character at a time, '0' to the left child and '1' to the right,
// and emit the letter when a leaf is reached; end items report whether the
// walk stopped away from the root. Writing cfg_data sets the root and returns
// the walk to it. One item is taken every cycle while results are being
// drained; each result passes the item and result registers into the queue.
// The rate is set by the walk loop: the registered child record from the
// table's read port feeds, through the leaf check and the left/right select,
// the read address of the next step. A three-entry result queue decouples
// the output, so a decode or end item stalls only when that queue, counting
// a result still on its way in, is full.
module huffman_bit_decoder
	import hbd_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire logic [IDX_W-1:0] cfg_data,
	hbd_in_if.sink                din,
	hbd_out_if.source             dout
);

	in_item_t         in_item;
	out_item_t        res_item;
	out_item_t        out_item;
	logic             res_valid;
	logic [LVL_W-1:0] level;

	assign in_item = '{
		opcode:      din.opcode,
		node_index:  din.node_index,
		left_index:  din.left_index,
		right_index: din.right_index,
		is_leaf:     din.is_leaf,
		leaf_letter: din.leaf_letter,
		code_char:   din.code_char
	};

	hbd_walk u_walk (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.in_valid  (din.valid),
		.in_item   (in_item),
		.in_ready  (din.ready),
		.level     (level),
		.res_valid (res_valid),
		.res_item  (res_item)
	);

	hbd_out_fifo u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_item (res_item),
		.level     (level),
		.out_valid (dout.valid),
		.out_item  (out_item),
		.out_ready (dout.ready)
	);

	assign dout.symbol       = out_item.symbol;
	assign dout.symbol_valid = out_item.symbol_valid;
	assign dout.stream_end   = out_item.stream_end;
	assign dout.incomplete   = out_item.incomplete;

endmodule
`default_nettype wire
